// ===== hw/rtl/mtsc_pkg.sv =====
`default_nettype none

package mtsc_pkg;

    localparam int FRAME_W    = 32;
    localparam int TIMEOUT_W  = 24;
    localparam int FPC_W      = 14;
    localparam int IDX_W      = 6;
    localparam int REQ_W      = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd468;
    localparam logic [FPC_W-1:0]     FPC_RST     = 14'd1024;

    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_TIMEOUT = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NETWORK_SYNC = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_PER   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CLIENT = 4'd3;

    typedef enum logic [1:0] {
        MODE_STOPPED     = 2'd0,
        MODE_STARTING    = 2'd1,
        MODE_ROLLING     = 2'd2,
        MODE_NETSTARTING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SLOT_STOPPED  = 2'd0,
        SLOT_STARTING = 2'd1,
        SLOT_ROLLING  = 2'd2
    } slot_state_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_CYCLE_END    = 3'd0,
        REQ_COMMAND      = 3'd1,
        REQ_LOCATE       = 3'd2,
        REQ_CLIENT_UPD   = 3'd3,
        REQ_CLIENT_READY = 3'd4
    } req_t;

    // What a cycle end does to each present client slot at or above the first client index.
    typedef enum logic [1:0] {
        STAMP_NONE  = 2'd0,
        STAMP_START = 2'd1,
        STAMP_HALT  = 2'd2
    } stamp_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECIDE = 3'd1,
        ST_SWEEP  = 3'd2,
        ST_FINISH = 3'd3,
        ST_READ   = 3'd4,
        ST_LOOK   = 3'd5,
        ST_RESULT = 3'd6
    } fsm_t;

    typedef struct packed {
        logic        present;
        logic        active;
        slot_state_t state;
    } slot_t;

    typedef struct packed {
        logic  en;
        slot_t data;
    } slot_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtsc_slot_store.sv =====
`default_nettype none

module mtsc_slot_store #(
    parameter int CLIENTS = 64,
    parameter int AW      = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mtsc_pkg::slot_wr_t wr,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [AW-1:0]     rd_addr,
    output mtsc_pkg::slot_t        rd_word
);

    mtsc_pkg::slot_t slot_mem [CLIENTS];
    logic [CLIENTS-1:0] valid_reg;
    mtsc_pkg::slot_t    rd_data_reg;
    logic               rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            slot_mem[wr_addr] <= wr.data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // An entry that was never written since reset reads as an empty slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/media_transport_sync_controller_unit.sv =====
// Cycle end: decide, a sweep from first_client to CLIENTS-1 (none below
// first_client are visited), finish, read, look, result. Other requests: read,
// look, result. No request is taken until the result is registered. The cycle-end
// length is set by the sweep over the client store, one slot per cycle on its port.
// aresetn (synchronous) restores the register defaults, stops the transport and
// empties every client slot at once through per-slot valid bits.
`default_nettype none

module media_transport_sync_controller_unit #(
    parameter int CLIENTS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: command[0], new_frame[32:1], client_index[38:33],
    //          client_present[39], client_active[40], zero fill
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mtsc_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: req_type[2:0]
    input  wire logic [mtsc_pkg::REQ_W-1:0]        s_tuser,
    // m_tdata: transport_state[1:0], current_frame[33:2], locate_pending[34],
    //          client_state_out[36:35], zero fill
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mtsc_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mtsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [mtsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CW0 = $clog2(CLIENTS + 1);
    localparam int CW  = (CW0 > mtsc_pkg::IDX_W) ? CW0 : mtsc_pkg::IDX_W;

    // Configuration registers.
    logic [mtsc_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                           netsync_reg, netsync_next;
    logic [mtsc_pkg::FPC_W-1:0]     fpc_reg, fpc_next;
    logic [mtsc_pkg::IDX_W-1:0]     first_reg, first_next;

    // Transport state.
    mtsc_pkg::fsm_t                 state_reg, state_next;
    mtsc_pkg::mode_t                mode_reg, mode_next;
    logic                           latched_cmd_reg, latched_cmd_next;
    logic                           prev_cmd_reg, prev_cmd_next;
    logic [mtsc_pkg::TIMEOUT_W-1:0] sync_reg, sync_next;
    logic [mtsc_pkg::FRAME_W-1:0]   frame_now_reg, frame_now_next;
    logic [mtsc_pkg::FRAME_W-1:0]   frame_pend_reg, frame_pend_next;
    logic [mtsc_pkg::FRAME_W-1:0]   req_frame_reg, req_frame_next;
    logic                           arrived_reg, arrived_next;
    logic                           locate_reg, locate_next;

    // Sequencer working state.
    mtsc_pkg::stamp_t               stamp_reg, stamp_next;
    logic                           check_reg, check_next;
    logic                           all_roll_reg, all_roll_next;
    logic [CW-1:0]                  scnt_reg, scnt_next;
    logic                           pv_reg, pv_next;
    logic [AW-1:0]                  paddr_reg, paddr_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // Request payload and result registers.
    mtsc_pkg::req_t                 req_reg;
    logic [CW-1:0]                  idx_reg;
    logic                           present_in_reg;
    logic                           active_in_reg;
    mtsc_pkg::slot_state_t          cstate_reg, cstate_next;
    logic [mtsc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    mtsc_pkg::slot_wr_t             wr;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  rd_addr;
    mtsc_pkg::slot_t                rd_word;
    mtsc_pkg::slot_t                new_word;
    mtsc_pkg::mode_t                mode_after;
    logic                           accept;
    logic                           issue;
    logic                           idx_ok;
    logic                           start_cmd;
    logic                           stop_cmd;

    mtsc_slot_store #(
        .CLIENTS (CLIENTS),
        .AW      (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    assign s_tready  = (state_reg == mtsc_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign idx_ok    = (idx_reg < CW'(CLIENTS));
    assign start_cmd = (latched_cmd_reg != prev_cmd_reg) && latched_cmd_reg;
    assign stop_cmd  = (latched_cmd_reg != prev_cmd_reg) && !latched_cmd_reg;

    always_comb begin
        timeout_next     = timeout_reg;
        netsync_next     = netsync_reg;
        fpc_next         = fpc_reg;
        first_next       = first_reg;
        state_next       = state_reg;
        mode_next        = mode_reg;
        latched_cmd_next = latched_cmd_reg;
        prev_cmd_next    = prev_cmd_reg;
        sync_next        = sync_reg;
        frame_now_next   = frame_now_reg;
        frame_pend_next  = frame_pend_reg;
        req_frame_next   = req_frame_reg;
        arrived_next     = arrived_reg;
        locate_next      = locate_reg;
        stamp_next       = stamp_reg;
        check_next       = check_reg;
        all_roll_next    = all_roll_reg;
        scnt_next        = scnt_reg;
        pv_next          = pv_reg;
        paddr_next       = paddr_reg;
        cstate_next      = cstate_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        wr               = '0;
        wr_addr          = idx_reg[AW-1:0];
        rd_addr          = idx_reg[AW-1:0];
        new_word         = rd_word;
        mode_after       = mode_reg;
        issue            = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_addr)
                mtsc_pkg::CFG_SYNC_TIMEOUT: timeout_next = cfg_wdata[mtsc_pkg::TIMEOUT_W-1:0];
                mtsc_pkg::CFG_NETWORK_SYNC: netsync_next = cfg_wdata[0];
                mtsc_pkg::CFG_FRAMES_PER:   fpc_next     = cfg_wdata[mtsc_pkg::FPC_W-1:0];
                mtsc_pkg::CFG_FIRST_CLIENT: first_next   = cfg_wdata[mtsc_pkg::IDX_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            mtsc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (mtsc_pkg::req_t'(s_tuser))
                        mtsc_pkg::REQ_CYCLE_END: state_next = mtsc_pkg::ST_DECIDE;
                        mtsc_pkg::REQ_COMMAND: begin
                            latched_cmd_next = s_tdata[0];
                            state_next       = mtsc_pkg::ST_READ;
                        end
                        mtsc_pkg::REQ_LOCATE: begin
                            req_frame_next = s_tdata[32:1];
                            arrived_next   = 1'b1;
                            state_next     = mtsc_pkg::ST_READ;
                        end
                        default: state_next = mtsc_pkg::ST_READ;
                    endcase
                end
            end

            // Latch the frame, edge-detect the command and choose the transition.
            mtsc_pkg::ST_DECIDE: begin
                frame_now_next = frame_pend_reg;
                prev_cmd_next  = latched_cmd_reg;
                stamp_next     = mtsc_pkg::STAMP_NONE;
                check_next     = 1'b0;
                all_roll_next  = 1'b1;
                pv_next        = 1'b0;
                scnt_next      = CW'(first_reg);
                state_next     = mtsc_pkg::ST_SWEEP;
                unique case (mode_reg)
                    mtsc_pkg::MODE_STOPPED: begin
                        if (start_cmd) begin
                            mode_next  = mtsc_pkg::MODE_STARTING;
                            stamp_next = mtsc_pkg::STAMP_START;
                            sync_next  = timeout_reg;
                        end else if (locate_reg) begin
                            stamp_next = mtsc_pkg::STAMP_HALT;
                        end
                    end
                    mtsc_pkg::MODE_STARTING: begin
                        if (stop_cmd) begin
                            mode_next  = mtsc_pkg::MODE_STOPPED;
                            stamp_next = mtsc_pkg::STAMP_HALT;
                        end else if (locate_reg) begin
                            stamp_next = mtsc_pkg::STAMP_START;
                            sync_next  = timeout_reg;
                        end else begin
                            sync_next  = sync_reg - 24'd1;
                            check_next = 1'b1;
                        end
                    end
                    mtsc_pkg::MODE_ROLLING: begin
                        if (stop_cmd) begin
                            mode_next  = mtsc_pkg::MODE_STOPPED;
                            stamp_next = mtsc_pkg::STAMP_HALT;
                        end else if (locate_reg) begin
                            mode_next  = mtsc_pkg::MODE_STARTING;
                            stamp_next = mtsc_pkg::STAMP_START;
                            sync_next  = timeout_reg;
                        end
                    end
                    default: ;
                endcase
            end

            // One slot is read per cycle; the slot read in the previous cycle is
            // checked against rolling and stamped back into the store.
            mtsc_pkg::ST_SWEEP: begin
                issue      = (scnt_reg < CW'(CLIENTS));
                rd_addr    = scnt_reg[AW-1:0];
                wr_addr    = paddr_reg;
                pv_next    = issue;
                paddr_next = scnt_reg[AW-1:0];
                if (issue) begin
                    scnt_next = scnt_reg + CW'(1);
                end else begin
                    state_next = mtsc_pkg::ST_FINISH;
                end
                if (pv_reg && rd_word.present) begin
                    if (rd_word.state != mtsc_pkg::SLOT_ROLLING) begin
                        all_roll_next = 1'b0;
                    end
                    if (stamp_reg == mtsc_pkg::STAMP_START) begin
                        new_word.state = rd_word.active ? mtsc_pkg::SLOT_STARTING
                                                        : mtsc_pkg::SLOT_ROLLING;
                        wr.en          = 1'b1;
                    end else if (stamp_reg == mtsc_pkg::STAMP_HALT) begin
                        new_word.state = mtsc_pkg::SLOT_STOPPED;
                        wr.en          = 1'b1;
                    end
                end
                wr.data = new_word;
            end

            mtsc_pkg::ST_FINISH: begin
                if (check_reg && ((sync_reg == '0) || all_roll_reg)) begin
                    mode_after = netsync_reg ? mtsc_pkg::MODE_NETSTARTING
                                             : mtsc_pkg::MODE_ROLLING;
                end
                mode_next = mode_after;
                if (mode_after == mtsc_pkg::MODE_ROLLING) begin
                    frame_pend_next = frame_now_reg + mtsc_pkg::FRAME_W'(fpc_reg);
                end
                locate_next = arrived_reg;
                if (arrived_reg) begin
                    frame_pend_next = req_frame_reg;
                end
                arrived_next = 1'b0;
                state_next   = mtsc_pkg::ST_READ;
            end

            mtsc_pkg::ST_READ: begin
                state_next = mtsc_pkg::ST_LOOK;
            end

            // A client update or client ready updates the addressed slot here; the slot's new state is reported.
            mtsc_pkg::ST_LOOK: begin
                unique case (req_reg)
                    mtsc_pkg::REQ_CLIENT_UPD: begin
                        if (idx_ok) begin
                            new_word.present = present_in_reg;
                            new_word.active  = active_in_reg;
                            if (!present_in_reg) begin
                                new_word.state = mtsc_pkg::SLOT_STOPPED;
                            end
                            wr.en = 1'b1;
                        end
                    end
                    mtsc_pkg::REQ_CLIENT_READY: begin
                        if (idx_ok && rd_word.present
                                && (rd_word.state == mtsc_pkg::SLOT_STARTING)) begin
                            new_word.state = mtsc_pkg::SLOT_ROLLING;
                            wr.en          = 1'b1;
                        end
                    end
                    default: ;
                endcase
                wr.data     = new_word;
                cstate_next = idx_ok ? new_word.state : mtsc_pkg::SLOT_STOPPED;
                state_next  = mtsc_pkg::ST_RESULT;
            end

            mtsc_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, cstate_reg, locate_reg, frame_now_reg, mode_reg};
                    state_next    = mtsc_pkg::ST_IDLE;
                end
            end

            default: state_next = mtsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= mtsc_pkg::TIMEOUT_RST;
            netsync_reg     <= 1'b0;
            fpc_reg         <= mtsc_pkg::FPC_RST;
            first_reg       <= '0;
            state_reg       <= mtsc_pkg::ST_IDLE;
            mode_reg        <= mtsc_pkg::MODE_STOPPED;
            latched_cmd_reg <= 1'b0;
            prev_cmd_reg    <= 1'b0;
            sync_reg        <= '0;
            frame_now_reg   <= '0;
            frame_pend_reg  <= '0;
            req_frame_reg   <= '0;
            arrived_reg     <= 1'b0;
            locate_reg      <= 1'b0;
            stamp_reg       <= mtsc_pkg::STAMP_NONE;
            check_reg       <= 1'b0;
            all_roll_reg    <= 1'b0;
            scnt_reg        <= '0;
            pv_reg          <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            timeout_reg     <= timeout_next;
            netsync_reg     <= netsync_next;
            fpc_reg         <= fpc_next;
            first_reg       <= first_next;
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            latched_cmd_reg <= latched_cmd_next;
            prev_cmd_reg    <= prev_cmd_next;
            sync_reg        <= sync_next;
            frame_now_reg   <= frame_now_next;
            frame_pend_reg  <= frame_pend_next;
            req_frame_reg   <= req_frame_next;
            arrived_reg     <= arrived_next;
            locate_reg      <= locate_next;
            stamp_reg       <= stamp_next;
            check_reg       <= check_next;
            all_roll_reg    <= all_roll_next;
            scnt_reg        <= scnt_next;
            pv_reg          <= pv_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg        <= mtsc_pkg::req_t'(s_tuser);
            idx_reg        <= CW'(s_tdata[38:33]);
            present_in_reg <= s_tdata[39];
            active_in_reg  <= s_tdata[40];
        end
        paddr_reg   <= paddr_next;
        cstate_reg  <= cstate_next;
        m_tdata_reg <= m_tdata_next;
    end

    // A result is only ever raised from the result state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == mtsc_pkg::ST_RESULT))
        else $error("result raised outside the result state");

    // When the first client lies inside the store, the sweep counter never runs past its end.
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mtsc_pkg::ST_SWEEP) && (CW'(first_reg) < CW'(CLIENTS))
            |-> (scnt_reg <= CW'(CLIENTS)))
        else $error("sweep counter beyond the client store");

    // Net-starting is left only through reset.
    a_net_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == mtsc_pkg::MODE_NETSTARTING) |=> (mode_reg == mtsc_pkg::MODE_NETSTARTING))
        else $error("transport left net-starting");

    // The client store is never written while the block waits for a request.
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mtsc_pkg::ST_IDLE) |-> !wr.en)
        else $error("client store written while idle");

    // The locate flag changes only when a cycle end completes.
    a_locate_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (locate_reg != $past(locate_reg)) |-> $past(state_reg == mtsc_pkg::ST_FINISH))
        else $error("locate flag changed outside a cycle end");

endmodule

`default_nettype wire
